FILE: design/drc_pkg.sv
`default_nettype none

package drc_pkg;

    localparam int LIST_DEPTH = 64;
    localparam int FIELD_W    = 13;
    localparam int EXT_W      = FIELD_W + 2;
    localparam int CNT_W      = $clog2(LIST_DEPTH + 1);
    localparam int RECT_W     = 4 * FIELD_W;
    localparam int TDATA_W    = ((RECT_W + 7) / 8) * 8;

    localparam logic [FIELD_W-1:0] EXTENT_MAX = {FIELD_W{1'b1}};

    localparam logic OP_ADD   = 1'b0;
    localparam logic OP_FLUSH = 1'b1;

    // x in the lowest bits
    typedef struct packed {
        logic        [FIELD_W-1:0] h;
        logic        [FIELD_W-1:0] w;
        logic signed [FIELD_W-1:0] y;
        logic signed [FIELD_W-1:0] x;
    } rect_t;

    // rect traveling down the chain; rem counts occupied cells still ahead
    typedef struct packed {
        logic             valid;
        logic             done;
        logic             appended;
        logic [CNT_W-1:0] rem;
        rect_t            rect;
    } tok_t;

    function automatic logic signed [EXT_W-1:0] sext(input logic [FIELD_W-1:0] v);
        sext = {{(EXT_W - FIELD_W){v[FIELD_W-1]}}, v};
    endfunction

    function automatic logic signed [EXT_W-1:0] zext(input logic [FIELD_W-1:0] v);
        zext = {{(EXT_W - FIELD_W){1'b0}}, v};
    endfunction

    function automatic logic rect_hit(input rect_t a, input rect_t b);
        logic signed [EXT_W-1:0] ax0;
        logic signed [EXT_W-1:0] ax1;
        logic signed [EXT_W-1:0] bx0;
        logic signed [EXT_W-1:0] bx1;
        logic signed [EXT_W-1:0] ay0;
        logic signed [EXT_W-1:0] ay1;
        logic signed [EXT_W-1:0] by0;
        logic signed [EXT_W-1:0] by1;
        ax0 = sext(a.x);
        ax1 = ax0 + zext(a.w);
        bx0 = sext(b.x);
        bx1 = bx0 + zext(b.w);
        ay0 = sext(a.y);
        ay1 = ay0 + zext(a.h);
        by0 = sext(b.y);
        by1 = by0 + zext(b.h);
        rect_hit = (ax0 < bx1) && (bx0 < ax1) && (ay0 < by1) && (by0 < ay1);
    endfunction

    function automatic rect_t rect_merge(input rect_t a, input rect_t b);
        logic signed [EXT_W-1:0] ax0;
        logic signed [EXT_W-1:0] ax1;
        logic signed [EXT_W-1:0] bx0;
        logic signed [EXT_W-1:0] bx1;
        logic signed [EXT_W-1:0] ay0;
        logic signed [EXT_W-1:0] ay1;
        logic signed [EXT_W-1:0] by0;
        logic signed [EXT_W-1:0] by1;
        logic signed [EXT_W-1:0] rx0;
        logic signed [EXT_W-1:0] rx1;
        logic signed [EXT_W-1:0] ry0;
        logic signed [EXT_W-1:0] ry1;
        logic signed [EXT_W-1:0] dw;
        logic signed [EXT_W-1:0] dh;
        rect_t                   r;
        ax0 = sext(a.x);
        ax1 = ax0 + zext(a.w);
        bx0 = sext(b.x);
        bx1 = bx0 + zext(b.w);
        ay0 = sext(a.y);
        ay1 = ay0 + zext(a.h);
        by0 = sext(b.y);
        by1 = by0 + zext(b.h);
        rx0 = (ax0 < bx0) ? ax0 : bx0;
        rx1 = (ax1 > bx1) ? ax1 : bx1;
        ry0 = (ay0 < by0) ? ay0 : by0;
        ry1 = (ay1 > by1) ? ay1 : by1;
        dw  = rx1 - rx0;
        dh  = ry1 - ry0;
        r.x = rx0[FIELD_W-1:0];
        r.y = ry0[FIELD_W-1:0];
        r.w = (dw > zext(EXTENT_MAX)) ? EXTENT_MAX : dw[FIELD_W-1:0];
        r.h = (dh > zext(EXTENT_MAX)) ? EXTENT_MAX : dh[FIELD_W-1:0];
        rect_merge = r;
    endfunction

endpackage

`default_nettype wire

FILE: design/drc_cell.sv
`default_nettype none

module drc_cell
    import drc_pkg::*;
(
    input  wire   clk,
    input  wire   rst_n,
    input  tok_t  tok_in,
    output tok_t  tok_out,
    input  wire   shift,
    input  rect_t ent_in,
    output rect_t ent_out
);

    tok_t  tok_reg;
    tok_t  tok_next;
    rect_t entry_reg;
    rect_t entry_next;

    always_comb
    begin
        tok_next   = tok_in;
        entry_next = entry_reg;
        if (tok_in.rem != '0)
        begin
            tok_next.rem = tok_in.rem - 1'b1;
        end
        if (shift)
        begin
            entry_next = ent_in;
        end
        else if (tok_in.valid && !tok_in.done)
        begin
            // first free cell: append
            if (tok_in.rem == '0)
            begin
                entry_next        = tok_in.rect;
                tok_next.done     = 1'b1;
                tok_next.appended = 1'b1;
            end
            else if (rect_hit(entry_reg, tok_in.rect))
            begin
                entry_next    = rect_merge(entry_reg, tok_in.rect);
                tok_next.done = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg <= '0;
        end
        else
        begin
            tok_reg <= tok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign tok_out = tok_reg;
    assign ent_out = entry_reg;

endmodule

`default_nettype wire

FILE: design/dirty_rect_coalescer_unit.sv
`default_nettype none

// channel  dir  data                                        tuser  tlast
// s_*      in   tdata: rect_x, rect_y, rect_w, rect_h (56b)  op     -
// m_*      out  tdata: out_x, out_y, out_w, out_h (56b)      -      last
//
// Add: the rect walks one cell per cycle; input stalls until the token leaves the last cell,
//   so the next add is accepted only after the previous one has passed the whole chain.
// Flush of n rects: one per cycle while m_tready holds, shifted out of cell 0;
//   input stalls until all n are loaded, m_tready stalls included (last result may still be pending).
// Reset clears the fill count and the chain tokens; cell contents are not cleared.
// The output register lets the list shift in the cycle a result is taken.

module dirty_rect_coalescer_unit
    import drc_pkg::*;
(
    input  wire                clk,
    input  wire                rst_n,
    input  wire                s_tvalid,
    output logic               s_tready,
    input  wire  [TDATA_W-1:0] s_tdata,   // rect_x, rect_y, rect_w, rect_h
    input  wire                s_tuser,   // op
    output logic               m_tvalid,
    input  wire                m_tready,
    output logic [TDATA_W-1:0] m_tdata,   // out_x, out_y, out_w, out_h
    output logic               m_tlast
);

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_ADD   = 3'b010,
        ST_FLUSH = 3'b100
    } state_t;

    state_t           state_reg;
    state_t           state_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    rect_t            out_data_reg;
    logic             out_last_reg;
    logic             accept;
    logic             load;
    logic             shift;
    tok_t             tok_chain [LIST_DEPTH+1];
    rect_t            ent_chain [LIST_DEPTH+1];

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    always_comb
    begin
        tok_chain[0].valid    = accept && (s_tuser == OP_ADD);
        tok_chain[0].done     = 1'b0;
        tok_chain[0].appended = 1'b0;
        tok_chain[0].rem      = count_reg;
        tok_chain[0].rect     = rect_t'(s_tdata[RECT_W-1:0]);
    end

    assign ent_chain[LIST_DEPTH] = '0;

    genvar gi;
    generate
        for (gi = 0; gi < LIST_DEPTH; gi++)
        begin : g_cell
            drc_cell u_cell (
                .clk     (clk),
                .rst_n   (rst_n),
                .tok_in  (tok_chain[gi]),
                .tok_out (tok_chain[gi+1]),
                .shift   (shift),
                .ent_in  (ent_chain[gi+1]),
                .ent_out (ent_chain[gi])
            );
        end
    endgenerate

    assign load  = (state_reg == ST_FLUSH) && (count_reg != '0) &&
                   (!out_valid_reg || m_tready);
    assign shift = load;

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        out_valid_next = out_valid_reg;
        if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = (s_tuser == OP_FLUSH) ? ST_FLUSH : ST_ADD;
                end
            end
            ST_ADD:
            begin
                if (tok_chain[LIST_DEPTH].valid)
                begin
                    state_next = ST_IDLE;
                    if (tok_chain[LIST_DEPTH].appended)
                    begin
                        count_next = count_reg + 1'b1;
                    end
                end
            end
            ST_FLUSH:
            begin
                if (count_reg == '0)
                begin
                    state_next = ST_IDLE;
                end
                else if (load)
                begin
                    count_next     = count_reg - 1'b1;
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_data_reg <= ent_chain[0];
            out_last_reg <= (count_reg == CNT_W'(1));
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(TDATA_W - RECT_W){1'b0}}, out_data_reg};
    assign m_tlast  = out_last_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(LIST_DEPTH))
        else $error("fill count above list depth");

    a_token_exit_in_add: assert property (@(posedge clk) disable iff (!rst_n)
        tok_chain[LIST_DEPTH].valid |-> (state_reg == ST_ADD))
        else $error("token left the chain outside an add");

    a_append_room: assert property (@(posedge clk) disable iff (!rst_n)
        (tok_chain[LIST_DEPTH].valid && tok_chain[LIST_DEPTH].appended)
            |-> (count_reg < CNT_W'(LIST_DEPTH)))
        else $error("append into a full list");

    a_flush_ends: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_FLUSH) && (count_reg == '0)) |=> (state_reg == ST_IDLE))
        else $error("flush did not end on empty list");

endmodule

`default_nettype wire

FILE: bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import drc_pkg::*;

    localparam int TAIL_ITEMS = 60;
    localparam int ITEM_TARGET = 440;

    typedef struct packed {
        logic  op;
        rect_t r;
    } damage_item_t;

    typedef struct packed {
        rect_t r;
        logic  last;
    } flushed_rect_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    logic [TDATA_W-1:0] s_tdata = '0;
    logic               s_tuser = OP_ADD;
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    logic [TDATA_W-1:0] m_tdata;
    logic               m_tlast;

    damage_item_t  pending_items[$];
    flushed_rect_t flush_expect[$];
    rect_t         damage_list[LIST_DEPTH];
    int            dirty_count = 0;
    int            items_queued = 0;
    int            items_taken = 0;
    int            mismatches = 0;
    bit            s_taken = 1'b0;
    int            send_gap = 0;
    int            send_calm = 0;
    int            recv_gap = 0;
    int            recv_calm = 0;

    dirty_rect_coalescer_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always #5 clk = ~clk;

    task automatic note_mismatch(string what, int got, int want);
        $display("%0t: %s: got %0d, expected %0d", $realtime, what, got, want);
        mismatches++;
    endtask

    function automatic bit boxes_cross(rect_t a, rect_t b);
        int ax;
        int ay;
        int bx;
        int by;
        ax = $signed(a.x);
        ay = $signed(a.y);
        bx = $signed(b.x);
        by = $signed(b.y);
        return ax < bx + int'(b.w) && bx < ax + int'(a.w) &&
               ay < by + int'(b.h) && by < ay + int'(a.h);
    endfunction

    function automatic rect_t bounding_box(rect_t a, rect_t b);
        int    x0;
        int    y0;
        int    x1;
        int    y1;
        rect_t r;
        x0 = $signed(a.x) < $signed(b.x) ? $signed(a.x) : $signed(b.x);
        y0 = $signed(a.y) < $signed(b.y) ? $signed(a.y) : $signed(b.y);
        x1 = $signed(a.x) + int'(a.w);
        if ($signed(b.x) + int'(b.w) > x1)
            x1 = $signed(b.x) + int'(b.w);
        y1 = $signed(a.y) + int'(a.h);
        if ($signed(b.y) + int'(b.h) > y1)
            y1 = $signed(b.y) + int'(b.h);
        r.x = x0[FIELD_W-1:0];
        r.y = y0[FIELD_W-1:0];
        r.w = (x1 - x0 > int'(EXTENT_MAX)) ? EXTENT_MAX : FIELD_W'(x1 - x0);
        r.h = (y1 - y0 > int'(EXTENT_MAX)) ? EXTENT_MAX : FIELD_W'(y1 - y0);
        return r;
    endfunction

    task automatic apply_damage(logic op, rect_t r);
        bit merged;
        flushed_rect_t e;
        merged = 1'b0;
        if (op == OP_ADD) begin
            for (int i = 0; i < dirty_count && !merged; i++) begin
                if (boxes_cross(damage_list[i], r)) begin
                    damage_list[i] = bounding_box(damage_list[i], r);
                    merged = 1'b1;
                end
            end
            if (!merged && dirty_count < LIST_DEPTH) begin
                damage_list[dirty_count] = r;
                dirty_count++;
            end
        end else begin
            for (int i = 0; i < dirty_count; i++) begin
                e.r = damage_list[i];
                e.last = (i == dirty_count - 1);
                flush_expect.push_back(e);
            end
            dirty_count = 0;
        end
    endtask

    task automatic check_flushed(rect_t got, logic got_last);
        flushed_rect_t want;
        if (flush_expect.size() == 0) begin
            note_mismatch("rect with none expected, x", $signed(got.x), 0);
            return;
        end
        want = flush_expect.pop_front();
        if (got.x !== want.r.x)
            note_mismatch("out_x", $signed(got.x), $signed(want.r.x));
        if (got.y !== want.r.y)
            note_mismatch("out_y", $signed(got.y), $signed(want.r.y));
        if (got.w !== want.r.w)
            note_mismatch("out_w", got.w, want.r.w);
        if (got.h !== want.r.h)
            note_mismatch("out_h", got.h, want.r.h);
        if (got_last !== want.last)
            note_mismatch("last", got_last, want.last);
    endtask

    task automatic queue_add(int x, int y, int w, int h);
        damage_item_t item;
        item.op = OP_ADD;
        item.r.x = x[FIELD_W-1:0];
        item.r.y = y[FIELD_W-1:0];
        item.r.w = w[FIELD_W-1:0];
        item.r.h = h[FIELD_W-1:0];
        pending_items.push_back(item);
        items_queued++;
    endtask

    task automatic queue_flush();
        damage_item_t item;
        item.op = OP_FLUSH;
        item.r = '0;
        pending_items.push_back(item);
        items_queued++;
    endtask

    task automatic queue_grid(int n);
        int bx;
        int by;
        int stride;
        bx = $urandom_range(0, 7000);
        by = $urandom_range(0, 7000);
        bx -= 4096;
        by -= 4096;
        stride = $urandom_range(10, 60);
        // disjoint cells, some touching the neighbor; past LIST_DEPTH they drop
        for (int i = 0; i < n; i++)
            queue_add(bx + (i % 8) * stride, by + (i / 8) * stride,
                      stride - $urandom_range(0, 3), stride - $urandom_range(0, 3));
    endtask

    // sender
    always @(negedge clk) begin
        damage_item_t item;
        if (rst_n && (!s_tvalid || s_taken)) begin
            if (send_gap > 0) begin
                send_gap--;
                s_tvalid <= 1'b0;
            end else if (pending_items.size() == 0) begin
                s_tvalid <= 1'b0;
            end else if (pending_items.size() > TAIL_ITEMS && send_calm == 0 &&
                         $urandom_range(0, 5) == 0) begin
                send_gap = $urandom_range(0, 16);
                s_tvalid <= 1'b0;
            end else begin
                if (send_calm > 0)
                    send_calm--;
                else if ($urandom_range(0, 24) == 0)
                    send_calm = $urandom_range(10, 80);
                item = pending_items.pop_front();
                s_tvalid <= 1'b1;
                s_tuser <= item.op;
                s_tdata <= {{(TDATA_W - RECT_W){1'b0}}, item.r};
            end
        end
        s_taken = 1'b0;
    end

    // receiver
    always @(negedge clk) begin
        if (rst_n) begin
            if (recv_gap > 0) begin
                recv_gap--;
                m_tready <= 1'b0;
            end else if (pending_items.size() > TAIL_ITEMS && recv_calm == 0 &&
                         $urandom_range(0, 5) == 0) begin
                recv_gap = $urandom_range(0, 16);
                m_tready <= 1'b0;
            end else begin
                if (recv_calm > 0)
                    recv_calm--;
                else if ($urandom_range(0, 19) == 0)
                    recv_calm = $urandom_range(20, 120);
                m_tready <= 1'b1;
            end
        end
    end

    // monitor
    always @(posedge clk) begin
        if (rst_n && s_tvalid && s_tready) begin
            apply_damage(s_tuser, rect_t'(s_tdata[RECT_W-1:0]));
            s_taken = 1'b1;
            items_taken++;
        end
        if (rst_n && m_tvalid && m_tready)
            check_flushed(rect_t'(m_tdata[RECT_W-1:0]), m_tlast);
    end

    initial begin
        int kind;
        int n;
        int bx;
        int by;
        int w;
        int h;

        // directed
        queue_flush();
        queue_add(4095, 4095, 8191, 8191);
        queue_add(-4096, -4096, 8191, 8191);
        queue_add(-4096, -4096, 8191, 8191);
        queue_add(4000, 4000, 200, 200);
        queue_add(0, 0, 0, 0);
        queue_flush();
        queue_add(0, 0, 10, 10);
        queue_add(10, 0, 10, 10);
        queue_add(0, 10, 10, 10);
        queue_add(5, 5, 10, 10);
        queue_add(-4096, -4096, 0, 0);
        queue_add(-4096, 4095, 8191, 0);
        queue_flush();
        queue_flush();

        // full list with drops
        queue_grid(68);
        queue_add(-4096, -4096, 8191, 8191);
        queue_flush();

        while (items_queued < ITEM_TARGET) begin
            kind = $urandom_range(0, 9);
            case (kind)
                0, 1, 2, 3, 9: begin
                    bx = $urandom_range(0, 7800);
                    by = $urandom_range(0, 7800);
                    bx -= 4096;
                    by -= 4096;
                    n = $urandom_range(1, 12);
                    for (int i = 0; i < n; i++)
                        queue_add(bx + $urandom_range(0, 200), by + $urandom_range(0, 200),
                                  $urandom_range(0, 80), $urandom_range(0, 80));
                end
                4, 5: begin
                    n = $urandom_range(1, 6);
                    for (int i = 0; i < n; i++) begin
                        bx = $urandom_range(0, 8191);
                        by = $urandom_range(0, 8191);
                        queue_add(bx - 4096, by - 4096,
                                  $urandom_range(0, 8191), $urandom_range(0, 8191));
                    end
                end
                6: begin
                    queue_grid($urandom_range(40, 70));
                    if ($urandom_range(0, 1) == 0)
                        queue_add($urandom_range(0, 8191) - 4096, $urandom_range(0, 8191) - 4096,
                                  $urandom_range(0, 400), $urandom_range(0, 400));
                end
                7: begin
                    // edge-to-edge strip, nothing merges
                    bx = $urandom_range(0, 3000);
                    by = $urandom_range(0, 7800);
                    bx -= 4096;
                    by -= 4096;
                    w = $urandom_range(1, 100);
                    h = $urandom_range(0, 100);
                    n = $urandom_range(1, 8);
                    for (int i = 0; i < n; i++)
                        queue_add(bx + i * w, by, w, h);
                end
                default: begin
                    if ($urandom_range(0, 1) == 0)
                        queue_add($urandom_range(0, 8191) - 4096, $urandom_range(0, 8191) - 4096,
                                  0, $urandom_range(0, 8191));
                end
            endcase
            if (kind != 9 && $urandom_range(0, 7) != 0)
                queue_flush();
        end
        queue_flush();

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        wait (items_taken == items_queued);
        wait (flush_expect.size() == 0);
        repeat (3 * LIST_DEPTH) @(posedge clk);
        if (mismatches == 0)
            $display("dirty_rect_coalescer_unit: match");
        else
            $display("dirty_rect_coalescer_unit: mismatch");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("dirty_rect_coalescer_unit: mismatch");
        $finish;
    end

endmodule
